// ===== sv/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; compiled first.
package uer_pkg;

  localparam int unsigned TICK_W    = 16;  // phase tick counter
  localparam int unsigned IVL_W     = 17;  // interval counter
  localparam int unsigned DIST_W    = 12;  // distance, tenths of cm
  localparam int unsigned THR_W     = 12;
  localparam int unsigned TRIG_W    = 10;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  // width * SCALE_MUL >> SCALE_SHIFT gives tenths of cm (round trip, truncated)
  localparam int unsigned MUL_W       = 14;
  localparam int unsigned PROD_W      = TICK_W + MUL_W;
  localparam int unsigned SCALE_SHIFT = 16;
  localparam int unsigned SCALED_W    = PROD_W - SCALE_SHIFT;

  localparam logic [MUL_W-1:0]    SCALE_MUL    = 14'd11239;
  localparam logic [SCALED_W-1:0] MIN_TENTHS   = 14'd20;
  localparam logic [SCALED_W-1:0] MAX_TENTHS   = 14'd4000;
  localparam logic [IVL_W-1:0]    INTERVAL_MAX = 17'h1FFFF;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RST  = 12'd300;
  localparam logic [TRIG_W-1:0] TRIG_RST = 10'd10;
  localparam logic [TMO_W-1:0]  TMO_RST  = 16'd30000;
  localparam logic [IVL_W-1:0]  IVL_RST  = 17'd60000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRIG_W    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL  = 2'd3;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              valid;
    logic              obstacle;
  } reading_t;

endpackage

// ===== sv/uer_if.sv =====
// Handshake channels of the ultrasonic echo ranger: echo samples, results
// and register writes. Depends on uer_pkg.
interface uer_echo_if;
  logic valid;
  logic ready;
  logic echo_level;
  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface uer_res_if;
  logic                      valid;
  logic                      ready;
  logic                      trigger_level;
  logic                      reading_done;
  logic [uer_pkg::DIST_W-1:0] distance_tenths;
  logic                      reading_valid;
  logic                      obstacle_near;
  logic                      busy_res;
  modport source (output valid, output trigger_level, output reading_done,
                  output distance_tenths, output reading_valid,
                  output obstacle_near, output busy_res, input ready);
  modport sink   (input valid, input trigger_level, input reading_done,
                  input distance_tenths, input reading_valid,
                  input obstacle_near, input busy_res, output ready);
endinterface

interface uer_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [uer_pkg::CFG_IDX_W-1:0] index;
  logic [uer_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/uer_scale.sv =====
// Pulse width to distance conversion with range limits and obstacle flag.
// Depends on uer_pkg.
module uer_scale (
  input  logic [uer_pkg::TICK_W-1:0] width_i,
  input  logic [uer_pkg::THR_W-1:0]  threshold_i,
  output uer_pkg::reading_t          reading_o
);
  import uer_pkg::*;

  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled;
  logic [DIST_W-1:0]   clipped;

  always_comb begin
    prod   = {{MUL_W{1'b0}}, width_i} * {{TICK_W{1'b0}}, SCALE_MUL};
    scaled = prod[PROD_W-1:SCALE_SHIFT];
    if (scaled < MIN_TENTHS) begin
      clipped = '0;
    end else if (scaled > MAX_TENTHS) begin
      clipped = MAX_TENTHS[DIST_W-1:0];
    end else begin
      clipped = scaled[DIST_W-1:0];
    end
    reading_o.distance = clipped;
    reading_o.valid    = (clipped != '0);
    reading_o.obstacle = (clipped != '0) && (clipped < threshold_i);
  end

endmodule

// ===== sv/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger, one channel: trigger sequencing, echo timing and
// distance reporting. Depends on uer_pkg, uer_if.sv and uer_scale.
//
// Usage
// - echo_i carries one echo line sample per microsecond tick. Each transfer
//   advances the ranging sequencer by exactly one tick.
// - result_o returns one result per accepted tick: the trigger drive for that
//   tick, a done pulse on the tick a measurement ends or times out, and the
//   latest distance (tenths of cm), valid and obstacle flags, plus busy.
// - cfg_i writes threshold, trigger width, echo timeout and measurement
//   interval (indexes 0..3). Always ready; write only while idle.
// Throughput
// - The result of a tick is registered in the output register by its own
//   transfer. One tick per cycle sustained while result_o is not stalled:
//   the whole step is a short combinational pass (one 16x14 multiply plus
//   compares) between the state registers and the output register.
// Stalls
// - echo_i.ready is high while the output register is empty or being drained,
//   so a stalled receiver holds exactly one result and back-pressures input.
// Reset
// - rst_ni clears the sequencer to idle, counters and last reading to zero,
//   and loads the register defaults (300, 10, 30000, 60000). First trigger
//   comes on the tick whose index equals the measurement interval.
module ultrasonic_echo_ranger (
  input  logic         clk_i,
  input  logic         rst_ni,
  uer_echo_if.sink     echo_i,
  uer_res_if.source    result_o,
  uer_cfg_if.sink      cfg_i
);
  import uer_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_e;

  typedef struct packed {
    logic              trigger;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              valid;
    logic              obstacle;
    logic              busy;
  } result_t;

  // Configuration
  logic [THR_W-1:0]  thr_q;
  logic [TRIG_W-1:0] trig_w_q;
  logic [TMO_W-1:0]  tmo_q;
  logic [IVL_W-1:0]  ivl_q;

  // Sequencer state
  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic [IVL_W-1:0]  ivl_cnt_q, ivl_cnt_d;
  reading_t          last_q, last_d;

  // Output register
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic     in_xfer, cfg_xfer;
  logic     start;
  phase_e   ph;
  logic [TICK_W-1:0] tk;
  logic [IVL_W-1:0]  ic;
  reading_t meas_rd;

  localparam reading_t NO_READING = '{distance: '0, valid: 1'b0, obstacle: 1'b0};

  assign echo_i.ready = !out_valid_q || result_o.ready;
  assign in_xfer      = echo_i.valid && echo_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign cfg_xfer     = cfg_i.valid;

  // Distance from the current pulse width; used only on the falling echo tick
  uer_scale u_scale (
    .width_i     (ticks_q),
    .threshold_i (thr_q),
    .reading_o   (meas_rd)
  );

  always_comb begin
    // A new measurement may only start from idle once the interval has run
    start = (phase_q == PH_IDLE) && (ivl_cnt_q >= ivl_q);
    ph    = start ? PH_TRIG : phase_q;
    tk    = start ? '0 : ticks_q;
    ic    = start ? '0 : ivl_cnt_q;

    phase_d = ph;
    ticks_d = tk;
    last_d  = last_q;
    res_d   = res_q;
    res_d.trigger = 1'b0;
    res_d.done    = 1'b0;
    res_d.busy    = (ph != PH_IDLE);

    case (ph)
      PH_TRIG: begin
        res_d.trigger = 1'b1;
        ticks_d = tk + 1'b1;
        if ((tk + 1'b1) >= {{(TICK_W-TRIG_W){1'b0}}, trig_w_q}) begin
          phase_d = PH_WAIT;
          ticks_d = '0;
        end
      end
      PH_WAIT: begin
        if (echo_i.echo_level) begin
          phase_d = PH_MEAS;
          ticks_d = TICK_W'(1);
        end else if (tk >= tmo_q) begin
          last_d     = NO_READING;
          phase_d    = PH_IDLE;
          ticks_d    = '0;
          res_d.done = 1'b1;
        end else begin
          ticks_d = tk + 1'b1;
        end
      end
      PH_MEAS: begin
        if (!echo_i.echo_level) begin
          last_d     = meas_rd;
          phase_d    = PH_IDLE;
          ticks_d    = '0;
          res_d.done = 1'b1;
        end else if (tk >= tmo_q) begin
          last_d     = NO_READING;
          phase_d    = PH_IDLE;
          ticks_d    = '0;
          res_d.done = 1'b1;
        end else begin
          ticks_d = tk + 1'b1;
        end
      end
      default: ;
    endcase

    // Saturating tick count since the last start
    ivl_cnt_d = (ic < INTERVAL_MAX) ? ic + 1'b1 : ic;

    res_d.distance = last_d.distance;
    res_d.valid    = last_d.valid;
    res_d.obstacle = last_d.obstacle;

    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RST;
      trig_w_q    <= TRIG_RST;
      tmo_q       <= TMO_RST;
      ivl_q       <= IVL_RST;
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      ivl_cnt_q   <= '0;
      last_q      <= NO_READING;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_xfer) begin
        case (cfg_i.index)
          CFG_IDX_THRESHOLD: thr_q    <= cfg_i.data[THR_W-1:0];
          CFG_IDX_TRIG_W:    trig_w_q <= cfg_i.data[TRIG_W-1:0];
          CFG_IDX_TIMEOUT:   tmo_q    <= cfg_i.data[TMO_W-1:0];
          CFG_IDX_INTERVAL:  ivl_q    <= cfg_i.data[IVL_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        phase_q   <= phase_d;
        ticks_q   <= ticks_d;
        ivl_cnt_q <= ivl_cnt_d;
        last_q    <= last_d;
        res_q     <= res_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.trigger_level   = res_q.trigger;
  assign result_o.reading_done    = res_q.done;
  assign result_o.distance_tenths = res_q.distance;
  assign result_o.reading_valid   = res_q.valid;
  assign result_o.obstacle_near   = res_q.obstacle;
  assign result_o.busy_res        = res_q.busy;

`ifndef ASSERT_OFF
  // Trigger and done only ever occur inside a measurement
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.trigger |-> res_q.busy)
    else $error("trigger outside measurement");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done |-> res_q.busy && !res_q.trigger)
    else $error("done outside measurement or during trigger");
  // Obstacle needs a valid reading; a valid reading lies in range
  a_obst_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.obstacle |-> res_q.valid)
    else $error("obstacle without valid reading");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid |-> (res_q.distance >= MIN_TENTHS[DIST_W-1:0]) &&
                    (res_q.distance <= MAX_TENTHS[DIST_W-1:0]))
    else $error("valid distance out of range");
  // An empty output register never back-pressures the echo stream
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> echo_i.ready)
    else $error("input stalled with empty output register");
`endif

endmodule

// ===== test/tb_ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_echo_ranger: drives echo ticks and register
// writes, predicts every result tick and compares it field by field.
// Depends on uer_pkg, the uer_*_if interfaces and the ranger RTL.
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 4;          // result register holds one result
  localparam int LIMIT_CYCLES  = 200_000;
  localparam int MAX_PRINTED   = 50;

  // Own copy of the range scaling: 0.01715 cm per us of round trip, 0.16 fixed point
  localparam int unsigned TENTHS_PER_TICK_Q16 = 11239;
  localparam int unsigned SHORTEST_TENTHS     = 20;
  localparam int unsigned LONGEST_TENTHS      = 4000;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_TRIGGER, SEQ_LISTEN, SEQ_TIMING} ranger_seq_e;

  typedef struct {
    logic              trigger;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              valid;
    logic              obstacle;
    logic              busy;
  } tick_outputs_t;

  logic clk;
  logic rst_n;

  uer_echo_if echo_bus ();
  uer_res_if  result_bus ();
  uer_cfg_if  cfg_bus ();

  ultrasonic_echo_ranger DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .echo_i   (echo_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the ranger: register copies plus sequencer state, advanced once
  // per accepted echo transfer.
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]  thr_setting;
  logic [TRIG_W-1:0] trig_setting;
  logic [TMO_W-1:0]  timeout_setting;
  logic [IVL_W-1:0]  interval_setting;

  ranger_seq_e       seq_state;
  logic [TICK_W-1:0] seq_ticks;
  logic [IVL_W-1:0]  ticks_since_start;
  reading_t          held_reading;

  tick_outputs_t ranger_outputs_q[$];

  int  ticks_sent;
  int  ticks_checked;
  int  readings_done;
  int  timeouts_seen;
  int  obstacles_seen;
  int  mismatch_count;
  bit  idle_enabled;
  int  hold_request;    // receiver hold-off length, picked up by the result sink

  // Latch a finished measurement; a failed wait leaves distance 0, invalid.
  function automatic void close_reading(input bit echo_ok, input logic [TICK_W-1:0] width);
    int unsigned w32;
    int unsigned tenths;
    w32    = 32'(width);
    tenths = 0;
    if (echo_ok) begin
      tenths = (w32 * TENTHS_PER_TICK_Q16) >> 16;
      if (tenths < SHORTEST_TENTHS) tenths = 0;
      if (tenths > LONGEST_TENTHS) tenths = LONGEST_TENTHS;
    end
    held_reading.distance = DIST_W'(tenths);
    held_reading.valid    = (tenths != 0);
    held_reading.obstacle = held_reading.valid && (held_reading.distance < thr_setting);
    seq_state = SEQ_IDLE;
    seq_ticks = '0;
    readings_done++;
    if (!echo_ok) timeouts_seen++;
    if (held_reading.obstacle) obstacles_seen++;
  endfunction

  // One microsecond tick of the sequencer; queues the outputs it should produce.
  function automatic void advance_ranger(input logic echo);
    tick_outputs_t o;
    o = '{default: '0};
    if (seq_state == SEQ_IDLE && ticks_since_start >= interval_setting) begin
      seq_state         = SEQ_TRIGGER;
      seq_ticks         = '0;
      ticks_since_start = '0;
    end
    o.busy = (seq_state != SEQ_IDLE);
    case (seq_state)
      SEQ_TRIGGER: begin
        // echo is ignored while the trigger is driven; width zero behaves as one
        o.trigger = 1'b1;
        seq_ticks = seq_ticks + 1'b1;
        if (seq_ticks >= trig_setting) begin
          seq_state = SEQ_LISTEN;
          seq_ticks = '0;
        end
      end
      SEQ_LISTEN: begin
        if (echo) begin
          seq_state = SEQ_TIMING;
          seq_ticks = TICK_W'(1);
        end else if (seq_ticks >= timeout_setting) begin
          close_reading(1'b0, '0);
          o.done = 1'b1;
        end else begin
          seq_ticks = seq_ticks + 1'b1;
        end
      end
      SEQ_TIMING: begin
        if (!echo) begin
          close_reading(1'b1, seq_ticks);
          o.done = 1'b1;
        end else if (seq_ticks >= timeout_setting) begin
          close_reading(1'b0, '0);
          o.done = 1'b1;
        end else begin
          seq_ticks = seq_ticks + 1'b1;
        end
      end
      default: ;
    endcase
    if (ticks_since_start != '1) ticks_since_start = ticks_since_start + 1'b1;
    o.distance = held_reading.distance;
    o.valid    = held_reading.valid;
    o.obstacle = held_reading.obstacle;
    ranger_outputs_q.push_back(o);
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t ns: result %0d, %s is %0d, expected %0d",
               $time, ticks_checked, field, got, want);
  endtask

  task automatic check_tick_result();
    tick_outputs_t want;
    if (ranger_outputs_q.size() == 0) begin
      flag_mismatch("result with nothing outstanding", 1, 0);
      return;
    end
    want = ranger_outputs_q.pop_front();
    if (result_bus.trigger_level !== want.trigger)
      flag_mismatch("trigger_level", int'(result_bus.trigger_level), int'(want.trigger));
    if (result_bus.reading_done !== want.done)
      flag_mismatch("reading_done", int'(result_bus.reading_done), int'(want.done));
    if (result_bus.distance_tenths !== want.distance)
      flag_mismatch("distance_tenths", int'(result_bus.distance_tenths),
                    int'(want.distance));
    if (result_bus.reading_valid !== want.valid)
      flag_mismatch("reading_valid", int'(result_bus.reading_valid), int'(want.valid));
    if (result_bus.obstacle_near !== want.obstacle)
      flag_mismatch("obstacle_near", int'(result_bus.obstacle_near), int'(want.obstacle));
    if (result_bus.busy_res !== want.busy)
      flag_mismatch("busy_res", int'(result_bus.busy_res), int'(want.busy));
    ticks_checked++;
  endtask

  // ---------------------------------------------------------------------------
  // Echo side: one transfer per tick. valid stays high between back-to-back
  // transfers and is only dropped when the sender idles or stops.
  // ---------------------------------------------------------------------------
  task automatic pause_echo(input int cycles);
    echo_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_tick(input logic level);
    if (idle_enabled && $urandom_range(0, 7) == 0) pause_echo($urandom_range(1, 9));
    echo_bus.valid      <= 1'b1;
    echo_bus.echo_level <= level;
    do @(posedge clk); while (echo_bus.ready !== 1'b1);
    advance_ranger(level);
    ticks_sent++;
  endtask

  // Stop offering and wait for every outstanding result, then let the block settle.
  task automatic drain_echo();
    echo_bus.valid <= 1'b0;
    while (ranger_outputs_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One well-formed measurement: low until the trigger is over (random levels while
  // the trigger is driven, as they must be ignored), lead low ticks of start wait,
  // a pulse of the given width, then low until the reading lands.
  task automatic run_measurement(input int lead, input int pulse);
    int n;
    while (seq_state != SEQ_LISTEN)
      send_tick(seq_state == SEQ_TRIGGER ? 1'($urandom_range(0, 1)) : 1'b0);
    for (n = 0; n < lead && seq_state == SEQ_LISTEN; n++) send_tick(1'b0);
    for (n = 0; n < pulse && seq_state != SEQ_IDLE; n++) send_tick(1'b1);
    while (seq_state != SEQ_IDLE) send_tick(1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes, only with nothing outstanding
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
  endtask

  task automatic program_ranger(input logic [THR_W-1:0] thr, input logic [TRIG_W-1:0] trig,
                                input logic [TMO_W-1:0] tmo, input logic [IVL_W-1:0] ivl);
    drain_echo();
    write_register(CFG_IDX_THRESHOLD, CFG_DAT_W'(thr));
    write_register(CFG_IDX_TRIG_W, CFG_DAT_W'(trig));
    write_register(CFG_IDX_TIMEOUT, CFG_DAT_W'(tmo));
    write_register(CFG_IDX_INTERVAL, CFG_DAT_W'(ivl));
    cfg_bus.valid <= 1'b0;
    thr_setting      = thr;
    trig_setting     = trig;
    timeout_setting  = tmo;
    interval_setting = ivl;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults: the default interval of 60000 keeps the block idle over the
  // first ticks. With only the interval shortened, the default ten tick trigger,
  // 30000 tick timeout and threshold of 300 apply: 117 ticks give 20 tenths, near.
  task automatic test_reset_defaults();
    idle_enabled = 1'b0;
    repeat (8) send_tick(1'($urandom_range(0, 1)));
    drain_echo();
    write_register(CFG_IDX_INTERVAL, CFG_DAT_W'(4));
    cfg_bus.valid <= 1'b0;
    interval_setting = IVL_W'(4);
    run_measurement(2, 117);
  endtask

  // Zero interval starts on the first idle tick, zero trigger width acts as one,
  // zero timeout gives up on the first low start-wait tick or a second high tick.
  task automatic test_special_settings();
    idle_enabled = 1'b1;
    program_ranger(THR_W'(300), '0, '0, '0);
    run_measurement(1, 0);
    run_measurement(0, 1);     // width one, far below the shortest range
    run_measurement(0, 2);
  endtask

  // Shortest range edge (116 vs 117 ticks) against a threshold of 20 tenths, then
  // pulse and start wait exactly at a short timeout and one tick past it.
  task automatic test_distance_edges();
    idle_enabled = 1'b1;
    program_ranger(THR_W'(20), TRIG_W'(1), TMO_W'(150), IVL_W'(2));
    run_measurement(0, 116);
    run_measurement(0, 117);   // 20 tenths, equal to threshold: no obstacle
    program_ranger(THR_W'(20), TRIG_W'(1), TMO_W'(12), IVL_W'(2));
    run_measurement(0, 12);
    run_measurement(0, 13);
    run_measurement(12, 0);
    run_measurement(13, 0);
  endtask

  // Largest register values: far below the full interval since the last start, so
  // the block stays idle and keeps the last reading whatever the echo line does.
  task automatic test_full_range();
    idle_enabled = 1'b0;
    program_ranger('1, '1, '1, '1);
    repeat (16) send_tick(1'($urandom_range(0, 1)));
  endtask

  // Receiver holds off for a long stretch while measurements keep being offered:
  // the result register fills and the echo input must stall without losing ticks.
  task automatic test_backpressure();
    idle_enabled = 1'b1;
    program_ranger(THR_W'(40), TRIG_W'(3), TMO_W'(200), IVL_W'(5));
    hold_request = 200;
    repeat (4) run_measurement($urandom_range(0, 8), $urandom_range(0, 20));
    drain_echo();
  endtask

  task automatic test_random_traffic();
    logic [THR_W-1:0]  thr;
    logic [TRIG_W-1:0] trig;
    logic [TMO_W-1:0]  tmo;
    logic [IVL_W-1:0]  ivl;
    int                round_start;
    int                lead;
    int                pulse;
    int                base;
    int                lo;
    for (int round = 0; round < 6; round++) begin
      case (round)
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = THR_W'(4000);
        default: thr = THR_W'($urandom_range(15, 60));
      endcase
      trig = ($urandom_range(0, 5) == 0) ? '0 : TRIG_W'($urandom_range(1, 12));
      case ($urandom_range(0, 7))
        0:       tmo = '0;
        1:       tmo = TMO_W'(1);
        2:       tmo = TMO_W'(124);   // room for pulses around the shortest range
        default: tmo = TMO_W'($urandom_range(16, 48));
      endcase
      ivl = ($urandom_range(0, 3) == 0) ? '0 : IVL_W'($urandom_range(1, 20));
      program_ranger(thr, trig, tmo, ivl);
      idle_enabled = (round != 3);   // one round runs flat out
      base = int'(tmo);
      lo   = (base > 0) ? base - 1 : 0;
      round_start = ticks_sent;
      while (ticks_sent - round_start < 30) begin
        if ($urandom_range(0, 4) == 0) begin
          // broken traffic: echo levels with no regard to where the sequencer is
          repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          lead = ($urandom_range(0, 4) == 0) ? $urandom_range(base + 1, lo)
                                             : $urandom_range(0, 6);
          case ($urandom_range(0, 3))
            0:       pulse = $urandom_range(0, 20);
            1:       pulse = $urandom_range(112, 122);   // around the shortest range
            2:       pulse = $urandom_range(base + 1, lo);
            default: pulse = $urandom_range(0, base + 2);
          endcase
          run_measurement(lead, pulse);
        end
      end
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady_tail();
    program_ranger(THR_W'(100), TRIG_W'(2), TMO_W'(16), IVL_W'(1));
    idle_enabled = 1'b0;
    repeat (3) run_measurement($urandom_range(0, 3), $urandom_range(0, 20));
  endtask

  // ---------------------------------------------------------------------------
  // Clock, result sink, sequence and watchdog
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Checks each result transfer, then chooses ready for the next cycle: a pending
  // hold-off first, then random stall bursts while idling is enabled, else ready high.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) check_tick_result();
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (hold_request > 0) begin
        stall_left   = hold_request - 1;
        hold_request = 0;
        result_bus.ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : run_tests
    rst_n               <= 1'b0;
    echo_bus.valid      <= 1'b0;
    echo_bus.echo_level <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    idle_enabled      = 1'b0;
    hold_request      = 0;
    ticks_sent        = 0;
    ticks_checked     = 0;
    readings_done     = 0;
    timeouts_seen     = 0;
    obstacles_seen    = 0;
    mismatch_count    = 0;
    // state after reset: idle, counters and last reading cleared, register defaults
    thr_setting       = THR_W'(300);
    trig_setting      = TRIG_W'(10);
    timeout_setting   = TMO_W'(30000);
    interval_setting  = IVL_W'(60000);
    seq_state         = SEQ_IDLE;
    seq_ticks         = '0;
    ticks_since_start = '0;
    held_reading      = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_defaults();
    test_special_settings();
    test_distance_edges();
    test_full_range();
    test_backpressure();
    test_random_traffic();
    test_steady_tail();
    drain_echo();

    $display("Covered %0d echo ticks and %0d readings across reset defaults, extremes",
             ticks_sent, readings_done);
    $display("and random settings: %0d timed out, %0d obstacles, long receiver hold-off.",
             timeouts_seen, obstacles_seen);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/uer_pkg.sv
sv/uer_if.sv
sv/uer_scale.sv
sv/ultrasonic_echo_ranger.sv
test/tb_ultrasonic_echo_ranger.sv
